### rtl/nbm_pkg.sv
package nbm_pkg;

  // axis and map geometry
  localparam int LOAD_POINTS = 16;
  localparam int RPM_POINTS  = 16;
  localparam int MAX_POINTS  = (LOAD_POINTS > RPM_POINTS) ? LOAD_POINTS : RPM_POINTS;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int LO_W        = $clog2(MAX_POINTS + 1);
  localparam int CELLS       = RPM_POINTS * LOAD_POINTS;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int NUM_LANES   = 2;
  localparam int LANE_LOAD   = 0;
  localparam int LANE_RPM    = 1;

  // field widths
  localparam int KIND_W  = 2;
  localparam int ENTRY_W = 4;
  localparam int AXIS_W  = 16;
  localparam int PW_W    = 32;
  localparam int PA_W    = 16;
  localparam int MAP_W   = PW_W + PA_W;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_LOAD = 2'd0,
    KIND_WR_RPM  = 2'd1,
    KIND_WR_CELL = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MAP
  } ctrl_state_t;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_PROBE,
    LS_NEIGH,
    LS_DONE
  } lane_phase_t;

  typedef struct packed {
    logic start;
    logic wr_load;
    logic wr_rpm;
    logic wr_cell;
    logic map_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } ctrl_stat_t;

  // low bits of an index as carried in the result item
  function automatic logic [ENTRY_W-1:0] idx_field(logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[ENTRY_W-1:0];
  endfunction

endpackage

### rtl/nearest_breakpoint_map_lookup.sv
// nearest breakpoint fuel map lookup
//
// input channel in_*: one item per handshake, in_tuser carries the kind
//   write load breakpoint, write rpm breakpoint and write map cell items
//   give no result
//   a lookup item gives exactly one result item on out_*
// lookup sequence: accept, then binary search probes on the axis rams
//   (both axes searched side by side, up to log2(points)+1 probes), a
//   read of the neighbor breakpoint when the query falls between two
//   points, the map ram read and the load into the result register
// throughput: one lookup at a time, next item taken as soon as the result
//   is in the result register; the probe chain on the axis ram read port
//   sets the lookup time
// stall: a result waiting on out_tready does not block new items; a
//   following lookup holds its map data until the result register frees
// reset: control returns to idle and the result register empties; axis
//   and map contents are undefined until written
module nearest_breakpoint_map_lookup
  import nbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_row, entry_col, breakpoint, cell_width, cell_angle, rpm_query, load_query
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pulse_width, pulse_angle, rpm_index, load_index
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  nbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .kind     (kind_t'(in_tuser)),
    .in_ready (in_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // field unpacking from the input item
  nbm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .entry_row  (in_tdata[3:0]),
    .entry_col  (in_tdata[7:4]),
    .breakpoint (in_tdata[23:8]),
    .cell_width (in_tdata[55:24]),
    .cell_angle (in_tdata[71:56]),
    .rpm_query  (in_tdata[87:72]),
    .load_query (in_tdata[103:88]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

### rtl/nbm_ram.sv
module nbm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nbm_ctrl.sv
module nbm_ctrl
  import nbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  kind_t      kind,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  ctrl_stat_t stat
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kind)
            KIND_WR_LOAD: cmd.wr_load = 1'b1;
            KIND_WR_RPM:  cmd.wr_rpm  = 1'b1;
            KIND_WR_CELL: cmd.wr_cell = 1'b1;
            KIND_LOOKUP: begin
              cmd.start = 1'b1;
              state_nxt = ST_SEARCH;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (stat.search_done) begin
          cmd.map_rd = 1'b1;
          state_nxt  = ST_MAP;
        end
      end
      ST_MAP: begin
        // map data held in the ram output until the result slot frees
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/nbm_datapath.sv
module nbm_datapath
  import nbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  input  logic [ENTRY_W-1:0]    entry_row,
  input  logic [ENTRY_W-1:0]    entry_col,
  input  logic [AXIS_W-1:0]     breakpoint,
  input  logic [PW_W-1:0]       cell_width,
  input  logic [PA_W-1:0]       cell_angle,
  input  logic [AXIS_W-1:0]     rpm_query,
  input  logic [AXIS_W-1:0]     load_query,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic [IDX_W-1:0] res_idx   [NUM_LANES];
  logic             lane_done [NUM_LANES];
  logic [31:0]      row_ext, col_ext, wr_cell_ext, rd_cell_ext;
  logic             row_ok_load, row_ok_rpm, col_ok;
  logic [MAP_W-1:0] map_rdata;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign row_ext     = 32'(entry_row);
  assign col_ext     = 32'(entry_col);
  assign row_ok_load = row_ext < 32'(LOAD_POINTS);
  assign row_ok_rpm  = row_ext < 32'(RPM_POINTS);
  assign col_ok      = col_ext < 32'(LOAD_POINTS);

  function automatic logic [AXIS_W:0] abs_gap(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b);
    return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  // one binary search lane per axis
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int N = (l == LANE_LOAD) ? LOAD_POINTS : RPM_POINTS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);
    localparam logic [IDX_W-1:0] INIT_MID = IDX_W'((N - 1) / 2);

    lane_phase_t       phase_r, phase_nxt;
    logic [AXIS_W-1:0] q_r, q_nxt, amid_r, amid_nxt, query_in, rdata;
    logic [LO_W-1:0]   lo_r, lo_nxt, lo_try;
    logic [IDX_W-1:0]  hi_r, hi_nxt, hi_try;
    logic [IDX_W-1:0]  mid_r, mid_nxt, mid_try, res_r, res_nxt, raddr;
    logic [LO_W:0]     sum;
    logic              gt_r, gt_nxt, lt, gt, brk, cont, we;

    if (l == LANE_LOAD) begin : g_load
      assign query_in = load_query;
      assign we       = cmd.wr_load && row_ok_load;
    end else begin : g_rpm
      assign query_in = rpm_query;
      assign we       = cmd.wr_rpm && row_ok_rpm;
    end

    nbm_ram #(
      .DEPTH (MAX_POINTS),
      .WIDTH (AXIS_W)
    ) u_axis (
      .clk   (clk),
      .we    (we),
      .waddr (row_ext[IDX_W-1:0]),
      .wdata (breakpoint),
      .re    (1'b1),
      .raddr (raddr),
      .rdata (rdata)
    );

    // probe outcome against the breakpoint read last cycle
    assign lt      = q_r < rdata;
    assign gt      = q_r > rdata;
    assign lo_try  = gt ? LO_W'(mid_r) + 1'b1 : lo_r;
    assign hi_try  = lt ? mid_r - 1'b1 : hi_r;
    assign brk     = lt && (mid_r == '0);
    assign cont    = !brk && (lo_try <= LO_W'(hi_try));
    assign sum     = (LO_W + 1)'(lo_try) + (LO_W + 1)'(hi_try);
    assign mid_try = sum[IDX_W:1];

    always_comb begin
      phase_nxt = phase_r;
      q_nxt     = q_r;
      lo_nxt    = lo_r;
      hi_nxt    = hi_r;
      mid_nxt   = mid_r;
      amid_nxt  = amid_r;
      gt_nxt    = gt_r;
      res_nxt   = res_r;
      raddr     = mid_r;
      if (cmd.start) begin
        q_nxt     = query_in;
        lo_nxt    = '0;
        hi_nxt    = LAST_IDX;
        mid_nxt   = INIT_MID;
        raddr     = INIT_MID;
        phase_nxt = LS_PROBE;
      end else begin
        unique case (phase_r)
          LS_PROBE: begin
            if (!lt && !gt) begin
              res_nxt   = mid_r;
              phase_nxt = LS_DONE;
            end else if (cont) begin
              lo_nxt  = lo_try;
              hi_nxt  = hi_try;
              mid_nxt = mid_try;
              raddr   = mid_try;
            end else begin
              // search over, fetch the neighbor on the query side unless mid is the axis end there
              amid_nxt = rdata;
              gt_nxt   = gt;
              if (gt) begin
                if (mid_r == LAST_IDX) begin
                  res_nxt   = LAST_IDX;
                  phase_nxt = LS_DONE;
                end else begin
                  raddr     = mid_r + 1'b1;
                  phase_nxt = LS_NEIGH;
                end
              end else begin
                if (mid_r == '0) begin
                  res_nxt   = '0;
                  phase_nxt = LS_DONE;
                end else begin
                  raddr     = mid_r - 1'b1;
                  phase_nxt = LS_NEIGH;
                end
              end
            end
          end
          LS_NEIGH: begin
            // tie keeps the lower index
            if (gt_r) begin
              res_nxt = (abs_gap(q_r, amid_r) > abs_gap(rdata, q_r)) ? mid_r + 1'b1 : mid_r;
            end else begin
              res_nxt = (abs_gap(q_r, rdata) > abs_gap(amid_r, q_r)) ? mid_r : mid_r - 1'b1;
            end
            phase_nxt = LS_DONE;
          end
          LS_IDLE, LS_DONE: ;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r <= LS_IDLE;
      end else begin
        phase_r <= phase_nxt;
      end
    end

    always_ff @(posedge clk) begin
      q_r    <= q_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      mid_r  <= mid_nxt;
      amid_r <= amid_nxt;
      gt_r   <= gt_nxt;
      res_r  <= res_nxt;
    end

    assign res_idx[l]   = res_r;
    assign lane_done[l] = (phase_r == LS_DONE);
  end

  // map cells, width and angle side by side
  assign wr_cell_ext = row_ext * 32'(LOAD_POINTS) + col_ext;
  assign rd_cell_ext = 32'(res_idx[LANE_RPM]) * 32'(LOAD_POINTS) + 32'(res_idx[LANE_LOAD]);

  nbm_ram #(
    .DEPTH (CELLS),
    .WIDTH (MAP_W)
  ) u_map (
    .clk   (clk),
    .we    (cmd.wr_cell && row_ok_rpm && col_ok),
    .waddr (wr_cell_ext[CELL_W-1:0]),
    .wdata ({cell_angle, cell_width}),
    .re    (cmd.map_rd),
    .raddr (rd_cell_ext[CELL_W-1:0]),
    .rdata (map_rdata)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {idx_field(res_idx[LANE_LOAD]), idx_field(res_idx[LANE_RPM]), map_rdata};
    end
  end

  assign stat.search_done = lane_done[LANE_LOAD] && lane_done[LANE_RPM];
  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule
